/* rtl/rfaf_pkg.sv */
`default_nettype none
package rfaf_pkg;

   // sample width of the ADC feeding the block
   localparam int unsigned ADC_BITS_DEF = 12;

   // register widths and reset values
   localparam int unsigned SUPPLY_W  = 16;
   localparam int unsigned FS_W      = 16;
   localparam int unsigned DIVR_W    = 24;
   localparam int unsigned CSR_W     = 24;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 16'd3300;
   localparam logic [FS_W-1:0]     FS_RST     = 16'd4095;
   localparam logic [DIVR_W-1:0]   DIVR_RST   = 24'd10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVR   = 2'd2;

   // result widths
   localparam int unsigned FORCE_W  = 20;
   localparam int unsigned GRAMS_W  = 17;
   localparam int unsigned STATUS_W = 3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_CONTACT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FLOOR     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_AT_SUPPLY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_VOUT_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_R_OVER    = 3'd4;

   // arithmetic constants
   localparam int unsigned SAMPLE_FLOOR = 10;
   localparam logic [39:0] R_LIMIT      = 40'd10000000;
   // (100000000 / r) / 100 equals 1000000 / r
   localparam logic [19:0] FORCE_NUM    = 20'd1000000;
   localparam logic [6:0]  GRAMS_MUL    = 7'd102;
   // x / 1000 as (x * ceil(2^37 / 1000)) >> 37, exact for x below 2^27
   localparam int unsigned GRAMS_RECIP_W = 28;
   localparam logic [GRAMS_RECIP_W-1:0] GRAMS_RECIP = 28'd137438954;
   localparam int unsigned GRAMS_SHIFT   = 37;

endpackage
`default_nettype wire

/* rtl/resistive_force_adc_to_force_core.sv */
`default_nettype none
// Pipeline: five single-register stages (A to E) plus 32 + 40 + 20 one-bit divider stages.
// Throughput: one sample per cycle; busy is always low, and the receiver
// cannot stall, so nothing stalls.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults: 3300 mV supply, full scale 4095, 10000 ohm divider.
module resistive_force_adc_to_force_core
   import rfaf_pkg::*;
#(
   parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [ADC_BITS-1:0]  req_adc_sample,
   output logic                      rsp_valid,
   output logic [FORCE_W-1:0]        rsp_force_millinewtons,
   output logic [GRAMS_W-1:0]        rsp_force_grams,
   output logic [STATUS_W-1:0]       rsp_status,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int unsigned PROD_W = ADC_BITS + SUPPLY_W;
   localparam int unsigned V_W    = 32;
   localparam int unsigned R_W    = 40;
   localparam int unsigned G_W    = 27;
   localparam int unsigned E_W    = G_W + GRAMS_RECIP_W;

   logic [SUPPLY_W-1:0] supply_ff;
   logic [FS_W-1:0]     fs_ff;
   logic [DIVR_W-1:0]   divr_ff;
   logic [FS_W-1:0]     fs_eff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RST;
         fs_ff     <= FS_RST;
         divr_ff   <= DIVR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SUPPLY: supply_ff <= csr_wdata[SUPPLY_W-1:0];
            CSR_FS:     fs_ff     <= csr_wdata[FS_W-1:0];
            CSR_DIVR:   divr_ff   <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign fs_eff = (fs_ff == '0) ? FS_W'(1) : fs_ff;
   assign busy   = 1'b0;

   // stage A: sample times supply
   logic              a_valid_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic              a_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      a_prod_ff  <= PROD_W'(req_adc_sample) * PROD_W'(supply_ff);
      a_floor_ff <= req_adc_sample < ADC_BITS'(SAMPLE_FLOOR);
   end

   // vout = product / full scale
   logic           v_valid;
   logic [V_W-1:0] v_quo;
   logic           v_floor;

   rfaf_div #(.NUM_W(V_W), .DEN_W(FS_W), .SIDE_W(1)) u_div_vout (
      .clock, .reset,
      .in_valid (a_valid_ff),
      .in_num   (V_W'(a_prod_ff)),
      .in_den   (fs_eff),
      .in_side  (a_floor_ff),
      .out_valid(v_valid),
      .out_quo  (v_quo),
      .out_side (v_floor)
   );

   // stage B: early status and resistance numerator
   logic                b_valid_ff;
   logic [R_W-1:0]      b_num_ff;
   logic [SUPPLY_W-1:0] b_den_ff;
   logic [STATUS_W-1:0] b_status_ff;
   logic [STATUS_W-1:0] b_status_in;
   logic [SUPPLY_W-1:0] b_drop;

   always_comb begin
      b_drop = supply_ff - v_quo[SUPPLY_W-1:0];
      priority if (v_floor)                     b_status_in = ST_FLOOR;
      else if (v_quo >= V_W'(supply_ff))        b_status_in = ST_AT_SUPPLY;
      else if (v_quo == '0)                     b_status_in = ST_VOUT_ZERO;
      else                                      b_status_in = ST_CONTACT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= v_valid;
      end
      b_num_ff    <= R_W'(divr_ff) * R_W'(b_drop);
      b_den_ff    <= v_quo[SUPPLY_W-1:0];
      b_status_ff <= b_status_in;
   end

   // r = divider * drop / vout
   logic                r_valid;
   logic [R_W-1:0]      r_quo;
   logic [STATUS_W-1:0] r_status;

   rfaf_div #(.NUM_W(R_W), .DEN_W(SUPPLY_W), .SIDE_W(STATUS_W)) u_div_res (
      .clock, .reset,
      .in_valid (b_valid_ff),
      .in_num   (b_num_ff),
      .in_den   (b_den_ff),
      .in_side  (b_status_ff),
      .out_valid(r_valid),
      .out_quo  (r_quo),
      .out_side (r_status)
   );

   // stage C: limit check, zero resistance taken as 1 ohm
   logic                c_valid_ff;
   logic [DIVR_W-1:0]   c_r_ff;
   logic [STATUS_W-1:0] c_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= r_valid;
      end
      c_r_ff      <= (r_quo == '0) ? DIVR_W'(1) : r_quo[DIVR_W-1:0];
      c_status_ff <= (r_status == ST_CONTACT && r_quo > R_LIMIT) ? ST_R_OVER : r_status;
   end

   // force = 1000000 / r
   logic                f_valid;
   logic [FORCE_W-1:0]  f_quo;
   logic [STATUS_W-1:0] f_status;

   rfaf_div #(.NUM_W(FORCE_W), .DEN_W(DIVR_W), .SIDE_W(STATUS_W)) u_div_force (
      .clock, .reset,
      .in_valid (c_valid_ff),
      .in_num   (FORCE_NUM),
      .in_den   (c_r_ff),
      .in_side  (c_status_ff),
      .out_valid(f_valid),
      .out_quo  (f_quo),
      .out_side (f_status)
   );

   // stage D: mask force on no contact, times 102
   logic                d_valid_ff;
   logic [G_W-1:0]      d_prod_ff;
   logic [FORCE_W-1:0]  d_force_ff;
   logic [STATUS_W-1:0] d_status_ff;
   logic [FORCE_W-1:0]  d_force_in;

   assign d_force_in = (f_status == ST_CONTACT) ? f_quo : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= f_valid;
      end
      d_prod_ff   <= G_W'(d_force_in) * G_W'(GRAMS_MUL);
      d_force_ff  <= d_force_in;
      d_status_ff <= f_status;
   end

   // stage E: grams = product / 1000 by reciprocal multiply
   logic                e_valid_ff;
   logic [GRAMS_W-1:0]  e_grams_ff;
   logic [FORCE_W-1:0]  e_force_ff;
   logic [STATUS_W-1:0] e_status_ff;
   logic [E_W-1:0]      e_prod;

   assign e_prod = E_W'(d_prod_ff) * E_W'(GRAMS_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
      e_grams_ff  <= e_prod[GRAMS_SHIFT +: GRAMS_W];
      e_force_ff  <= d_force_ff;
      e_status_ff <= d_status_ff;
   end

   assign rsp_valid              = e_valid_ff;
   assign rsp_force_grams        = e_grams_ff;
   assign rsp_force_millinewtons = e_force_ff;
   assign rsp_status             = e_status_ff;

endmodule
`default_nettype wire

/* rtl/rfaf_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per register stage.
module rfaf_div
   import rfaf_pkg::*;
#(
   parameter int unsigned NUM_W  = 32,
   parameter int unsigned DEN_W  = 16,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              valid_ff [1:NUM_W];
   logic [NUM_W-1:0]  num_ff   [1:NUM_W];
   logic [NUM_W-1:0]  quo_ff   [1:NUM_W];
   logic [DEN_W-1:0]  rem_ff   [1:NUM_W];
   logic [DEN_W-1:0]  den_ff   [1:NUM_W];
   logic [SIDE_W-1:0] side_ff  [1:NUM_W];

   for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
      logic              valid_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W:0]    diff;
      logic [DEN_W-1:0]  rem_in;

      // first stage takes the incoming beat
      if (k == 1) begin : g_head
         assign valid_prev = in_valid;
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign rem_prev   = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_tail
         assign valid_prev = valid_ff[k-1];
         assign num_prev   = num_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // shift in next numerator bit, subtract if it fits
      always_comb begin
         trial  = {rem_prev, num_prev[NUM_W-1]};
         ge     = trial >= {1'b0, den_prev};
         diff   = trial - {1'b0, den_prev};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         num_ff[k]  <= {num_prev[NUM_W-2:0], 1'b0};
         quo_ff[k]  <= {quo_prev[NUM_W-2:0], ge};
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quo   = quo_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule
`default_nettype wire

/* rtl/rfaf_checker.sv */
`default_nettype none
module rfaf_checker
   import rfaf_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [FORCE_W-1:0]  rsp_force_millinewtons,
   input wire logic [GRAMS_W-1:0]  rsp_force_grams,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // pipeline never refuses a beat
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // status within the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_R_OVER)
      else $error("bad status code");

   // no contact means zero force and zero grams
   a_zero_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_CONTACT |->
         rsp_force_millinewtons == '0 && rsp_force_grams == '0)
      else $error("force on no contact");

   // grams never exceed millinewtons, force within range
   a_grams_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 20'(rsp_force_grams) <= rsp_force_millinewtons &&
         rsp_force_millinewtons <= 20'd1000000)
      else $error("force out of range");

endmodule

bind resistive_force_adc_to_force_core rfaf_checker u_rfaf_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_force_millinewtons,
   .rsp_force_grams, .rsp_status
);
`default_nettype wire

/* dv/resistive_force_adc_to_force_core_tb.sv */
`default_nettype none
module resistive_force_adc_to_force_core_tb;
   import rfaf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ADC_W       = ADC_BITS_DEF;
   localparam int unsigned PIPE_CYCLES = 97;
   // index 3 decodes to no register
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [FORCE_W-1:0]  mn;
      logic [GRAMS_W-1:0]  grams;
      logic [STATUS_W-1:0] status;
   } force_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [ADC_W-1:0]     req_adc_sample = '0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   wire                  busy;
   wire                  rsp_valid;
   wire [FORCE_W-1:0]    rsp_force_millinewtons;
   wire [GRAMS_W-1:0]    rsp_force_grams;
   wire [STATUS_W-1:0]   rsp_status;

   // shadow copy of the registers
   logic [SUPPLY_W-1:0] supply_mv = SUPPLY_RST;
   logic [FS_W-1:0]     full_scale = FS_RST;
   logic [DIVR_W-1:0]   divider_r = DIVR_RST;

   force_beat_type pending_forces[$];
   int unsigned    errors = 0;
   bit             no_gaps = 1'b0;

   resistive_force_adc_to_force_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_adc_sample(req_adc_sample), .rsp_valid(rsp_valid),
      .rsp_force_millinewtons(rsp_force_millinewtons),
      .rsp_force_grams(rsp_force_grams), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // divider arithmetic at full width
   function automatic force_beat_type convert_sample(logic [ADC_W-1:0] s);
      logic [63:0] fs, vout, ohms, mn, g;
      force_beat_type b;
      fs = (full_scale == '0) ? 64'd1 : 64'(full_scale);
      mn = 64'd0;
      if (s < SAMPLE_FLOOR) begin
         b.status = ST_FLOOR;
      end else begin
         vout = (64'(s) * 64'(supply_mv)) / fs;
         if (vout >= 64'(supply_mv)) begin
            b.status = ST_AT_SUPPLY;
         end else if (vout == 64'd0) begin
            b.status = ST_VOUT_ZERO;
         end else begin
            ohms = (64'(divider_r) * (64'(supply_mv) - vout)) / vout;
            if (ohms > 64'd10000000) begin
               b.status = ST_R_OVER;
            end else begin
               if (ohms == 64'd0) ohms = 64'd1;
               mn = (64'd100000000 / ohms) / 64'd100;
               b.status = ST_CONTACT;
            end
         end
      end
      g       = (mn * 64'd102) / 64'd1000;
      b.mn    = mn[FORCE_W-1:0];
      b.grams = g[GRAMS_W-1:0];
      return b;
   endfunction

   // one register write, shadow updated alongside
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SUPPLY: supply_mv  = data[SUPPLY_W-1:0];
         CSR_FS:     full_scale = data[FS_W-1:0];
         CSR_DIVR:   divider_r  = data[DIVR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [SUPPLY_W-1:0] sv, logic [FS_W-1:0] fs,
                           logic [DIVR_W-1:0] dr);
      csr_write(CSR_SUPPLY, {8'($urandom), sv});
      csr_write(CSR_FS, {8'($urandom), fs});
      csr_write(CSR_DIVR, dr);
   endtask

   // send one sample beat, optional idle gap first
   task automatic send_sample(logic [ADC_W-1:0] s);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (busy);
      pending_forces.push_back(convert_sample(s));
   endtask

   // let the pipeline empty before touching registers
   task automatic drain;
      start <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 8) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      force_beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_forces.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: mN %0d g %0d st %0d",
                        rsp_force_millinewtons, rsp_force_grams, rsp_status);
         end else begin
            want = pending_forces.pop_front();
            if (want.mn !== rsp_force_millinewtons || want.grams !== rsp_force_grams
                || want.status !== rsp_status) begin
               errors++;
               if (errors <= 10)
                  $display("exp mN %0d g %0d st %0d, got mN %0d g %0d st %0d",
                           want.mn, want.grams, want.status, rsp_force_millinewtons,
                           rsp_force_grams, rsp_status);
            end
         end
      end
   end

   // reset defaults: floor, extremes, bit patterns
   task automatic test_defaults;
      send_sample(12'd0);
      send_sample(12'd9);
      send_sample(12'd10);
      send_sample(12'd11);
      send_sample(12'd2048);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'd4094);
      send_sample(12'd4095);    // vout lands on supply
      drain();
   endtask

   // special register settings
   task automatic test_corner_regs;
      set_regs(16'd1, 16'd4095, 24'd10000);      // vout rounds to zero
      send_sample(12'd10);
      send_sample(12'd4095);
      drain();
      set_regs(16'd3300, 16'd4095, 24'd10000000); // resistance above limit
      send_sample(12'd10);
      send_sample(12'd3000);
      drain();
      set_regs(16'd3300, 16'd4095, 24'd0);        // zero ohms, top force
      send_sample(12'd100);
      drain();
      set_regs(16'd0, 16'd4095, 24'd10000);       // zero supply
      send_sample(12'd500);
      drain();
      set_regs(16'd65535, 16'd0, 24'hFFFFFF);     // zero full scale
      send_sample(12'd10);
      drain();
      set_regs(16'd65535, 16'd65535, 24'hFFFFFF);
      send_sample(12'd4095);
      send_sample(12'd10);
      drain();
      csr_write(CSR_UNUSED, 24'hFFFFFF);          // ignored write
      send_sample(12'd2000);
      drain();
   endtask

   function automatic logic [CSR_W-1:0] pick_reg(int unsigned w, logic [CSR_W-1:0] rst);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CSR_W'(1);
         2: return CSR_W'((1 << w) - 1);
         3: return rst;
         default: return CSR_W'($urandom & ((1 << w) - 1));
      endcase
   endfunction

   // random phases with random register settings
   task automatic test_random;
      logic [ADC_W-1:0] s;
      for (int p = 0; p < 13; p++) begin
         if (p == 0) set_regs(SUPPLY_RST, FS_RST, DIVR_RST);
         else set_regs(SUPPLY_W'(pick_reg(SUPPLY_W, CSR_W'(SUPPLY_RST))),
                       FS_W'(pick_reg(FS_W, CSR_W'(FS_RST))),
                       DIVR_W'(pick_reg(DIVR_W, CSR_W'(DIVR_RST))));
         if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED, 24'($urandom));
         no_gaps = (p % 4 == 3);
         for (int i = 0; i < 145; i++) begin
            case ($urandom_range(0, 5))
               0: s = ADC_W'($urandom_range(0, 20));
               1: s = ADC_W'($urandom_range(4000, 4095));
               default: s = ADC_W'($urandom);
            endcase
            send_sample(s);
         end
         drain();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_corner_regs();
      test_random();
      if (pending_forces.size() != 0) errors++;
      if (errors == 0) begin
         $display("resistive_force_adc_to_force_core: match");
      end else begin
         $display("resistive_force_adc_to_force_core: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("resistive_force_adc_to_force_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
